@@ hdl/ptpc_pkg.sv @@
package ptpc_pkg;

    localparam int NS_W  = 30;
    localparam int SEC_W = 32;
    localparam int OFS_W = 31;
    localparam int INC_W = 8;

    localparam logic [NS_W:0]    NS_PER_SEC = 31'd1000000000;
    localparam logic [NS_W-1:0]  NS_MAX     = 30'd999999999;
    localparam logic [INC_W-1:0] INC_RESET  = 8'd20;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_ADJUST = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // input word after range checks, ready for the time update
    typedef struct packed {
        logic [1:0]       op;
        logic [NS_W-1:0]  set_ns;
        logic [SEC_W-1:0] set_sec;
        logic             adj_neg;
        logic [NS_W-1:0]  adj_mag;
    } ptpc_item_t;

endpackage

@@ hdl/ptpc_update.sv @@
module ptpc_update (
    input  ptpc_pkg::ptpc_item_t        item,
    input  logic [ptpc_pkg::NS_W-1:0]   ns_cur,
    input  logic [ptpc_pkg::SEC_W-1:0]  sec_cur,
    input  logic [ptpc_pkg::INC_W-1:0]  ns_inc,
    output logic [ptpc_pkg::NS_W-1:0]   ns_new,
    output logic [ptpc_pkg::SEC_W-1:0]  sec_new
);
    import ptpc_pkg::*;

    logic [NS_W:0] add_val;
    logic [NS_W:0] sum;
    logic [NS_W:0] diff;
    logic [NS_W:0] diff_wrap;
    logic          sub_mode;

    // tick and positive adjust share the adder; negative adjust subtracts
    assign sub_mode  = (item.op == OP_ADJUST) && item.adj_neg;
    assign add_val   = (item.op == OP_TICK) ? {{(NS_W+1-INC_W){1'b0}}, ns_inc}
                                            : {1'b0, item.adj_mag};
    assign sum       = {1'b0, ns_cur} + add_val;
    assign diff      = {1'b0, ns_cur} - {1'b0, item.adj_mag};
    assign diff_wrap = diff + NS_PER_SEC;

    always_comb begin
        ns_new  = ns_cur;
        sec_new = sec_cur;
        case (item.op)
            OP_TICK, OP_ADJUST: begin
                if (sub_mode) begin
                    if (diff[NS_W]) begin
                        ns_new  = diff_wrap[NS_W-1:0];
                        sec_new = sec_cur - 32'd1;
                    end else begin
                        ns_new = diff[NS_W-1:0];
                    end
                end else if (sum >= NS_PER_SEC) begin
                    ns_new  = NS_W'(sum - NS_PER_SEC);
                    sec_new = sec_cur + 32'd1;
                end else begin
                    ns_new = sum[NS_W-1:0];
                end
            end
            OP_SET: begin
                ns_new  = item.set_ns;
                sec_new = item.set_sec;
            end
            default: begin
                ns_new  = ns_cur;
                sec_new = sec_cur;
            end
        endcase
    end

endmodule

@@ hdl/ptp_time_of_day_counter_top.sv @@
// ptp time-of-day counter, digital rollover
// keeps seconds (32 bits) and nanoseconds (0..999999999) and returns the
// time after every input word.
// input channel s_*: one word per operation: tick adds the configured
// increment, set loads a new time, adjust adds a signed sub-second offset
// with carry or borrow into the seconds, read only returns the time.
// result channel m_*: one word per input word, in order.
// cfg_wen/cfg_wdata write the nanosecond increment per tick.
// after input acceptance a word passes the input register (where clamping
// of set and offset values is already done) and then the result register,
// which also takes the time update; m_tvalid rises when the word reaches
// the result register.
// throughput is one word per cycle while the receiver keeps m_tready high,
// set by the time update loop on the time registers.
// when the receiver stalls, the result register holds, then the input
// register fills and s_tready drops; nothing is lost.
// reset (aresetn low, synchronous) clears the time to zero, empties both
// registers and restores the increment to 20 ns.
module ptp_time_of_day_counter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // op[1:0], set_nanoseconds[31:2], set_seconds[63:32],
                                   // offset_ns[94:64], zero[95]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // nanoseconds[29:0], seconds[61:30], zero[63:62]
);
    import ptpc_pkg::*;

    logic [INC_W-1:0]  inc_reg;
    logic [NS_W-1:0]   ns_reg;
    logic [SEC_W-1:0]  sec_reg;
    logic [NS_W-1:0]   ns_next;
    logic [SEC_W-1:0]  sec_next;
    ptpc_item_t        item_reg;
    ptpc_item_t        item_next;
    logic              item_vld_reg;
    logic              out_vld_reg;
    logic              advance;
    logic              in_acc;

    logic [NS_W-1:0]   set_ns_raw;
    logic [OFS_W-1:0]  ofs_raw;
    logic [OFS_W-1:0]  ofs_neg;
    logic [OFS_W-1:0]  ofs_mag;

    assign advance  = item_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !item_vld_reg || advance;
    assign in_acc   = s_tvalid && s_tready;

    // clamp set and offset values on the way into the input register
    assign set_ns_raw = s_tdata[31:2];
    assign ofs_raw    = s_tdata[94:64];
    assign ofs_neg    = ~ofs_raw + 31'd1;
    assign ofs_mag    = ofs_raw[OFS_W-1] ? ofs_neg : ofs_raw;

    always_comb begin
        item_next.op      = s_tdata[1:0];
        item_next.set_ns  = (set_ns_raw > NS_MAX) ? NS_MAX : set_ns_raw;
        item_next.set_sec = s_tdata[63:32];
        item_next.adj_neg = ofs_raw[OFS_W-1];
        item_next.adj_mag = (ofs_mag > {1'b0, NS_MAX}) ? NS_MAX : ofs_mag[NS_W-1:0];
    end

    ptpc_update u_update (
        .item    (item_reg),
        .ns_cur  (ns_reg),
        .sec_cur (sec_reg),
        .ns_inc  (inc_reg),
        .ns_new  (ns_next),
        .sec_new (sec_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg      <= INC_RESET;
            ns_reg       <= '0;
            sec_reg      <= '0;
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                inc_reg <= cfg_wdata;
            end
            if (in_acc) begin
                item_vld_reg <= 1'b1;
            end else if (advance) begin
                item_vld_reg <= 1'b0;
            end
            if (advance) begin
                ns_reg      <= ns_next;
                sec_reg     <= sec_next;
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            item_reg <= item_next;
        end
    end

    // the time registers double as the result register
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, sec_reg, ns_reg};

endmodule

@@ tb/ptp_time_of_day_counter_top_tb.sv @@
module ptp_time_of_day_counter_top_tb;
    import ptpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 160;

    typedef struct packed {
        logic [1:0]  op;
        logic [29:0] set_ns;
        logic [31:0] set_sec;
        logic [30:0] ofs;
    } tod_cmd_t;

    typedef struct packed {
        logic [29:0] ns;
        logic [31:0] sec;
    } time_word_t;

    typedef struct packed {
        tod_cmd_t   cmd;
        logic       typed;
        time_word_t res;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;

    // time as the block should hold it, plus its increment register
    logic [29:0] tod_ns  = '0;
    logic [31:0] tod_sec = '0;
    logic [7:0]  inc_ns  = INC_RESET;

    time_word_t time_due_q[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         idle_pct       = 0;
    int         stall_pct      = 0;

    ptp_time_of_day_counter_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // directed words, walked once after reset with the reset increment of 20 ns
    dir_row_t dir_rows [22] = '{
        '{'{OP_READ,   30'd0,         32'd0,          31'd0},
          1'b1, '{30'd0, 32'd0}},
        '{'{OP_TICK,   30'd0,         32'd0,          31'd0},
          1'b1, '{30'd20, 32'd0}},
        '{'{OP_SET,    30'd999999999, 32'hFFFFFFFF,   31'd0},
          1'b1, '{30'd999999999, 32'hFFFFFFFF}},
        // tick across the second and the seconds wrap together
        '{'{OP_TICK,   30'd0,         32'd0,          31'd0},
          1'b1, '{30'd19, 32'd0}},
        '{'{OP_ADJUST, 30'd0,         32'd0,          31'(-20)},
          1'b1, '{30'd999999999, 32'hFFFFFFFF}},
        '{'{OP_ADJUST, 30'd0,         32'd0,          31'd1},
          1'b1, '{30'd0, 32'd0}},
        // set above range clamps
        '{'{OP_SET,    30'h3FFFFFFF,  32'd5,          31'd0},
          1'b1, '{30'd999999999, 32'd5}},
        // offsets beyond range saturate both ways
        '{'{OP_ADJUST, 30'd0,         32'd0,          31'h3FFFFFFF},
          1'b1, '{30'd999999998, 32'd6}},
        '{'{OP_ADJUST, 30'd0,         32'd0,          31'h40000000},
          1'b1, '{30'd999999999, 32'd5}},
        '{'{OP_ADJUST, 30'd0,         32'd0,          31'h7FFFFFFF},
          1'b1, '{30'd999999998, 32'd5}},
        '{'{OP_SET,    30'd0,         32'd0,          31'd0},
          1'b1, '{30'd0, 32'd0}},
        '{'{OP_ADJUST, 30'd0,         32'd0,          31'(-999999999)},
          1'b1, '{30'd1, 32'hFFFFFFFF}},
        '{'{OP_ADJUST, 30'd0,         32'd0,          31'd999999999},
          1'b1, '{30'd0, 32'd0}},
        // unused fields full of junk must not matter
        '{'{OP_READ,   30'h3FFFFFFF,  32'hFFFFFFFF,   31'h2AAAAAAA},
          1'b1, '{30'd0, 32'd0}},
        '{'{OP_TICK,   30'h15555555,  32'h5A5A5A5A,   31'h7FFFFFFF},
          1'b1, '{30'd20, 32'd0}},
        '{'{OP_ADJUST, 30'h2AAAAAAA,  32'hFFFFFFFF,   31'd0},
          1'b1, '{30'd20, 32'd0}},
        '{'{OP_SET,    30'd123456789, 32'hA5A5A5A5,   31'h55555555},
          1'b1, '{30'd123456789, 32'hA5A5A5A5}},
        '{'{OP_ADJUST, 30'd0,         32'd0,          31'(-123456789)},
          1'b1, '{30'd0, 32'hA5A5A5A5}},
        '{'{OP_ADJUST, 30'h1234567,   32'h0,          31'd500000000},
          1'b0, '{30'd0, 32'd0}},
        '{'{OP_ADJUST, 30'h0,         32'h89ABCDEF,   31'(-700000000)},
          1'b0, '{30'd0, 32'd0}},
        '{'{OP_SET,    30'd999999990, 32'h7FFFFFFF,   31'h3ABCDEF0},
          1'b0, '{30'd0, 32'd0}},
        '{'{OP_TICK,   30'h3FFFFFFF,  32'h0,          31'h0},
          1'b0, '{30'd0, 32'd0}}
    };

    function automatic time_word_t advance_time(input tod_cmd_t cmd);
        logic [31:0] sum;
        logic [30:0] mag;
        time_word_t  r;
        case (cmd.op)
            OP_TICK: begin
                sum = {2'b00, tod_ns} + {24'd0, inc_ns};
                if (sum >= NS_PER_SEC) begin
                    sum     = sum - NS_PER_SEC;
                    tod_sec = tod_sec + 32'd1;
                end
                tod_ns = sum[29:0];
            end
            OP_SET: begin
                tod_ns  = (cmd.set_ns > NS_MAX) ? NS_MAX : cmd.set_ns;
                tod_sec = cmd.set_sec;
            end
            OP_ADJUST: begin
                mag = cmd.ofs[30] ? (31'd0 - cmd.ofs) : cmd.ofs;
                if (mag > {1'b0, NS_MAX}) begin
                    mag = {1'b0, NS_MAX};
                end
                if (cmd.ofs[30]) begin
                    if ({1'b0, tod_ns} >= mag) begin
                        sum = {2'b00, tod_ns} - {1'b0, mag};
                    end else begin
                        sum     = {2'b00, tod_ns} + NS_PER_SEC - {1'b0, mag};
                        tod_sec = tod_sec - 32'd1;
                    end
                end else begin
                    sum = {2'b00, tod_ns} + {1'b0, mag};
                    if (sum >= NS_PER_SEC) begin
                        sum     = sum - NS_PER_SEC;
                        tod_sec = tod_sec + 32'd1;
                    end
                end
                tod_ns = sum[29:0];
            end
            default: ;
        endcase
        r.ns  = tod_ns;
        r.sec = tod_sec;
        return r;
    endfunction

    task automatic send_cmd(input tod_cmd_t cmd, input logic typed, input time_word_t typed_res);
        time_word_t due;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, cmd.ofs, cmd.set_sec, cmd.set_ns, cmd.op};
        do @(posedge aclk); while (!s_tready);
        due = advance_time(cmd);
        time_due_q.push_back(typed ? typed_res : due);
    endtask

    task automatic wait_drained();
        while (time_due_q.size() != 0) begin
            @(posedge aclk);
        end
        // let the two pipeline stages settle
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_increment(input logic [7:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        inc_ns   = value;
    endtask

    function automatic tod_cmd_t random_cmd();
        tod_cmd_t   cmd;
        int         pick;
        int signed  o;
        pick        = $urandom_range(0, 99);
        cmd.op      = (pick < 45) ? OP_TICK : (pick < 60) ? OP_SET :
                      (pick < 85) ? OP_ADJUST : OP_READ;
        cmd.set_ns  = 30'($urandom);
        cmd.set_sec = $urandom;
        cmd.ofs     = 31'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: cmd.set_ns = NS_MAX - 30'($urandom_range(0, 300));
            2: cmd.set_ns = NS_MAX + 30'($urandom_range(0, 30'h3FFFFFFF - 999999999));
            default: cmd.set_ns = 30'($urandom_range(0, 1000));
        endcase
        case ($urandom_range(0, 2))
            0: ;
            1: cmd.set_sec = 32'hFFFFFFFF - $urandom_range(0, 3);
            default: cmd.set_sec = $urandom_range(0, 3);
        endcase
        case ($urandom_range(0, 3))
            0: o = int'($urandom) >>> 1;
            1: o = $urandom_range(0, 999999999);
            2: o = $urandom_range(0, 300);
            default: o = 999999999 - $urandom_range(0, 2);
        endcase
        if (cmd.op == OP_ADJUST && $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1) == 1) begin
                o = -o;
            end
            cmd.ofs = o[30:0];
        end
        return cmd;
    endfunction

    task automatic set_pace(input int mode);
        case (mode)
            1:       begin idle_pct = 76; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 76; end
            3:       begin idle_pct = 18; stall_pct = 18; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // result side: random back-pressure and in-order compare
    always @(posedge aclk) begin
        time_word_t due;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (time_due_q.size() == 0) begin
                $error("result word with nothing due: nanoseconds %0d seconds %0d",
                       m_tdata[29:0], m_tdata[61:30]);
                mismatch_count++;
            end else begin
                due = time_due_q.pop_front();
                if (m_tdata[29:0] !== due.ns) begin
                    $error("nanoseconds: expected %0d, got %0d", due.ns, m_tdata[29:0]);
                    mismatch_count++;
                end
                if (m_tdata[61:30] !== due.sec) begin
                    $error("seconds: expected %0d, got %0d", due.sec, m_tdata[61:30]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ptp_time_of_day_counter_top verification failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] inc_plan [N_PHASES];
        inc_plan = '{8'd255, 8'd1, 8'd0, 8'd128, 8'd20, 8'd0, 8'd0, 8'd255};
        inc_plan[5] = 8'($urandom_range(1, 255));
        inc_plan[6] = 8'($urandom_range(1, 255));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_pace(0);
        for (int i = 0; i < 22; i++) begin
            send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_increment(inc_plan[p]);
            set_pace(p % 4);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                send_cmd(random_cmd(), 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        if (mismatch_count == 0) begin
            $display("ptp_time_of_day_counter_top verification clean");
        end else begin
            $display("ptp_time_of_day_counter_top verification failed");
        end
        $finish;
    end

endmodule
